### hw/rtl/g_exposure_tolerance_monitor_assert.svh
// Assertion macros shared by the exposure monitor RTL.
`ifndef G_EXPOSURE_TOLERANCE_MONITOR_ASSERT_SVH
`define G_EXPOSURE_TOLERANCE_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GETM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("getm: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GETM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("getm: next-cycle check failed");

`endif

### hw/rtl/getm_pkg.sv
package getm_pkg;

  // One word as it travels down the row of bin cells.
  typedef struct packed {
    logic [15:0] g;     // Q8.8 sample
    logic [31:0] t;     // timestamp in ms
    logic        fail;  // some bin already ran over its limit for this word
  } getm_word_t;

  localparam int unsigned GETM_FRAC_BITS = 24;

  // Floor integer square root of a 64-bit value.
  function automatic logic [63:0] getm_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bq;
    rem = v;
    res = 64'd0;
    bq  = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bq) begin
        rem = rem - (res + bq);
        res = (res >> 1) + bq;
      end else begin
        res = res >> 1;
      end
      bq = bq >> 2;
    end
    return res;
  endfunction

  // log2 of a Q8.8 value, result in Q24. Values below one are taken as one.
  function automatic logic [63:0] getm_log2_q24(input logic [15:0] x_q8);
    logic [15:0] x;
    logic [63:0] m;
    logic [63:0] frac;
    int unsigned p;
    x    = (x_q8 < 16'd256) ? 16'd256 : x_q8;
    p    = 0;
    frac = 64'd0;
    for (int k = 0; k < 16; k++) begin
      if (x[k]) begin
        p = k;
      end
    end
    m = 64'(x) << (30 - p);
    for (int k = 0; k < GETM_FRAC_BITS; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(p - 8) << GETM_FRAC_BITS) | frac;
  endfunction

  // Tolerance time in ms for a Q8.8 threshold: floor(32000 * g^-0.261).
  // Evaluated only while the design elaborates.
  function automatic logic [31:0] getm_limit(input logic [15:0] thr_q8);
    logic [63:0] l;
    logic [63:0] y;
    logic [63:0] yi;
    logic [63:0] yf;
    logic [63:0] r;
    logic [63:0] c;
    l  = getm_log2_q24(thr_q8);
    y  = (l * 64'd261 + 64'd500) / 64'd1000;
    yi = y >> GETM_FRAC_BITS;
    yf = y & ((64'd1 << GETM_FRAC_BITS) - 64'd1);
    r  = 64'd1 << 30;
    c  = getm_isqrt(64'd1 << 59);
    for (int k = 1; k <= GETM_FRAC_BITS; k++) begin
      if (yf[GETM_FRAC_BITS - k]) begin
        r = (r * c) >> 30;
      end
      c = getm_isqrt(c << 30);
    end
    if (yi > 64'd31) begin
      return 32'd0;
    end
    return 32'((64'd32000 * r) >> (64'd30 + yi));
  endfunction

endpackage

### hw/rtl/getm_cell.sv
// One threshold bin plus the pipeline register that hands the word onward.
module getm_cell import getm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] thr,
  input  logic [31:0] limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  getm_word_t  in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output getm_word_t  out_word
);

  logic        active;
  logic [31:0] start;
  logic        above;
  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic        over;
  logic        take;

  assign in_ready  = ~out_valid | out_ready;
  assign take      = in_valid & in_ready;
  assign above     = in_word.g > thr;
  assign start_eff = active ? start : in_word.t;
  assign elapsed   = in_word.t - start_eff;
  assign over      = above & (elapsed > limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        active <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word.g    <= in_word.g;
      out_word.t    <= in_word.t;
      out_word.fail <= in_word.fail | over;
      if (above & ~active) begin
        start <= in_word.t;
      end
    end
  end

endmodule

### hw/rtl/getm_out.sv
// End of the row: sticky survived flag, running peak and the output register.
module getm_out import getm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  getm_word_t  in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        survived,
  output logic [15:0] peak_g
);

  logic take;

  assign in_ready = ~out_valid | out_ready;
  assign take     = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      survived  <= 1'b1;
      peak_g    <= 16'd0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        survived <= survived & ~in_word.fail;
        if (in_word.g > peak_g) begin
          peak_g <= in_word.g;
        end
      end
    end
  end

endmodule

### hw/rtl/g_exposure_tolerance_monitor.sv
// Channel   | Direction | Fields in tdata, lowest bit first
// ----------+-----------+----------------------------------------------
// s_axis    | in        | g_sample[15:0], sample_time_ms[47:16]
// m_axis    | out       | survived[0], peak_g[16:1], zero pad [23:17]
//
// One word is taken per clock while s_axis_tready is high; every word yields
// one result word, registered in each bin cell and then in the output stage.
// Reset (rst, synchronous, active high) empties the row, clears every bin,
// sets survived and zeroes the peak. Each stage holds its word while the next
// one is full and stalled, so a stall on m_axis fills empty stages first and
// only then lowers s_axis_tready.
`include "g_exposure_tolerance_monitor_assert.svh"

module g_exposure_tolerance_monitor import getm_pkg::*; #(
  parameter int unsigned NUM_BINS         = 20,
  parameter int unsigned LOW_THRESHOLD_G  = 5,
  parameter int unsigned HIGH_THRESHOLD_G = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // g_sample[15:0], sample_time_ms[47:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // survived[0], peak_g[16:1], zero [23:17]
);

  // Thresholds are spaced evenly over NUM_BINS - 1 steps, rounded half up.
  localparam int unsigned D = NUM_BINS - 1;

  // Stage k feeds cell k; stage NUM_BINS feeds the output stage.
  getm_word_t  word [NUM_BINS + 1];
  logic        vld  [NUM_BINS + 1];
  logic        rdy  [NUM_BINS + 1];
  logic        survived;
  logic [15:0] peak_g;
  logic [NUM_BINS:1] busy;

  assign vld[0]       = s_axis_tvalid;
  assign s_axis_tready = rdy[0];
  assign word[0].g    = s_axis_tdata[15:0];
  assign word[0].t    = s_axis_tdata[47:16];
  assign word[0].fail = 1'b0;

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_bin
    // Threshold and tolerance of this bin are fixed at elaboration.
    localparam logic [31:0] BIN_NUM =
      32'(256 * (LOW_THRESHOLD_G * (D - i) + HIGH_THRESHOLD_G * i));
    localparam logic [31:0] BIN_RAW = (BIN_NUM + D / 2) / D;
    localparam logic [15:0] BIN_THR =
      (BIN_RAW > 32'h0000_FFFF) ? 16'hFFFF : BIN_RAW[15:0];
    localparam logic [31:0] BIN_LIMIT = getm_limit(BIN_THR);

    getm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .thr       (BIN_THR),
      .limit     (BIN_LIMIT),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_word   (word[i]),
      .out_valid (vld[i + 1]),
      .out_ready (rdy[i + 1]),
      .out_word  (word[i + 1])
    );

    assign busy[i + 1] = vld[i + 1];
  end

  getm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NUM_BINS]),
    .in_ready  (rdy[NUM_BINS]),
    .in_word   (word[NUM_BINS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .survived  (survived),
    .peak_g    (peak_g)
  );

  assign m_axis_tdata = {7'd0, peak_g, survived};

  // Once a bin has run past its tolerance, survived never comes back.
  `GETM_ASSERT_NEXT(a_survived_sticky, clk, rst, !survived, !survived)

  // The reported peak never decreases.
  `GETM_ASSERT_NEXT(a_peak_monotonic, clk, rst, 1'b1, peak_g >= $past(peak_g))

  // With the whole row and the output register empty, input must be open.
  `GETM_ASSERT_NOW(a_empty_accepts, clk, rst, (busy == '0) && !m_axis_tvalid,
                   s_axis_tready)

endmodule

### bench/exposure_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the exposure monitor, predicts the status word for
// every accepted sample word and compares it with what the block sends back.
module exposure_checker #(
  parameter int unsigned NUM_BINS         = 20,
  parameter int unsigned LOW_THRESHOLD_G  = 5,
  parameter int unsigned HIGH_THRESHOLD_G = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // g_sample[15:0], sample_time_ms[47:16]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // survived[0], peak_g[16:1], zero [23:17]
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic        survived;
    logic [15:0] peak_g;
  } status_t;

  // Per-bin thresholds (Q8.8) and tolerance times (ms), filled in at time zero.
  logic [15:0] thr_q8 [NUM_BINS];
  logic [31:0] tol_ms [NUM_BINS];

  logic [31:0] onset_ms [NUM_BINS];
  logic        above    [NUM_BINS];
  logic        alive;
  logic [15:0] peak_seen;
  status_t     status_q [$];
  int          fail_count = 0;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // floor(32000 * g^-0.261) in the same fixed-point steps as the block:
  // log2 in Q24 by squaring a Q30 mantissa, scale by 0.261, then 2^-frac
  // as a product of 2^-(2^-k) constants.
  function automatic logic [31:0] tolerance_ms(input logic [15:0] thr);
    logic [15:0] x;
    int          msb;
    logic [63:0] mant;
    logic [63:0] lg;
    logic [63:0] y;
    logic [63:0] yi;
    logic [23:0] yf;
    logic [63:0] r;
    logic [63:0] c;
    x   = (thr < 16'd256) ? 16'd256 : thr;
    msb = 0;
    for (int k = 0; k < 16; k++) begin
      if (x[k]) begin
        msb = k;
      end
    end
    mant = 64'(x) << (30 - msb);
    lg   = '0;
    for (int k = 0; k < 24; k++) begin
      mant = (mant * mant) >> 30;
      lg   = lg << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        lg   = lg | 64'd1;
      end
    end
    lg = (64'(msb - 8) << 24) | lg;
    y  = (lg * 64'd261 + 64'd500) / 64'd1000;
    yi = y >> 24;
    yf = y[23:0];
    r  = 64'd1 << 30;
    c  = floor_sqrt(64'd1 << 59);
    for (int k = 1; k <= 24; k++) begin
      if (yf[24 - k]) begin
        r = (r * c) >> 30;
      end
      c = floor_sqrt(c << 30);
    end
    if (yi > 64'd31) begin
      return 32'd0;
    end
    return 32'((64'd32000 * r) >> (64'd30 + yi));
  endfunction

  function automatic status_t apply_sample(input logic [15:0] g, input logic [31:0] now);
    status_t s;
    if (g > peak_seen) begin
      peak_seen = g;
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      if (g > thr_q8[i]) begin
        if (!above[i]) begin
          above[i]    = 1'b1;
          onset_ms[i] = now;
        end
        if (32'(now - onset_ms[i]) > tol_ms[i]) begin
          alive = 1'b0;
        end
      end else begin
        above[i]    = 1'b0;
        onset_ms[i] = '0;
      end
    end
    s.survived = alive;
    s.peak_g   = peak_seen;
    return s;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  initial begin
    int d;
    d = (NUM_BINS > 1) ? NUM_BINS - 1 : 1;
    for (int i = 0; i < NUM_BINS; i++) begin
      int t;
      t = (256 * (LOW_THRESHOLD_G * (d - i) + HIGH_THRESHOLD_G * i) + d / 2) / d;
      thr_q8[i] = (t > 65535) ? 16'hFFFF : 16'(t);
      tol_ms[i] = tolerance_ms(thr_q8[i]);
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        above[i]    = 1'b0;
        onset_ms[i] = '0;
      end
      alive     = 1'b1;
      peak_seen = '0;
      status_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          note_failure($sformatf("status word %h with none expected", m_axis_tdata));
        end else begin
          want = status_q.pop_front();
          if (m_axis_tdata[0] !== want.survived) begin
            note_failure($sformatf("survived mismatch, expected %0d, got %0d",
                                   want.survived, m_axis_tdata[0]));
          end
          if (m_axis_tdata[16:1] !== want.peak_g) begin
            note_failure($sformatf("peak_g mismatch, expected %h, got %h",
                                   want.peak_g, m_axis_tdata[16:1]));
          end
          if (m_axis_tdata[23:17] !== 7'd0) begin
            note_failure($sformatf("pad bits mismatch, expected 00, got %h",
                                   m_axis_tdata[23:17]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.insert(status_q.size(),
                        apply_sample(s_axis_tdata[15:0], s_axis_tdata[47:16]));
      end
    end
    mismatches  <= fail_count;
    outstanding <= status_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NUM_BINS         = 20;
  localparam int unsigned LOW_THRESHOLD_G  = 5;
  localparam int unsigned HIGH_THRESHOLD_G = 30;

  // Random stimulus runs until this many words have gone in; the closing
  // words bring the total to roughly 1650.
  localparam int RANDOM_END   = 1620;
  localparam int TOTAL_WORDS  = 1650;
  // Idle pattern changes after each third of the run.
  localparam int PHASE_WORDS  = 550;
  // Cycles in a row with no word moving on either channel before giving up.
  // A correct run never gets near this: the pipeline is NUM_BINS + 1 deep
  // and the receiver stalls at random, never for long stretches.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // g_sample[15:0], sample_time_ms[47:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // survived[0], peak_g[16:1], zero [23:17]

  int mismatches;
  int outstanding;
  int sent          = 0;
  int send_idle_pct = 15;
  int recv_idle_pct = 62;
  int stall_cycles  = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  g_exposure_tolerance_monitor #(
    .NUM_BINS         (NUM_BINS),
    .LOW_THRESHOLD_G  (LOW_THRESHOLD_G),
    .HIGH_THRESHOLD_G (HIGH_THRESHOLD_G)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The checker owns the prediction. Its threshold and tolerance tables are
  // also read here so that the stimulus can aim at bin boundaries.
  exposure_checker #(
    .NUM_BINS         (NUM_BINS),
    .LOW_THRESHOLD_G  (LOW_THRESHOLD_G),
    .HIGH_THRESHOLD_G (HIGH_THRESHOLD_G)
  ) i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one sample word and returns at the edge where it is taken. The
  // sender may idle a few cycles first. tvalid stays high on return, so the
  // caller either offers the next word or lowers tvalid itself.
  task automatic push_word(input logic [15:0] g, input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, g};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    sent++;
    if (sent == PHASE_WORDS) begin
      send_idle_pct = 62;
      recv_idle_pct = 15;
    end else if (sent == 2 * PHASE_WORDS) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Stops offering and waits until every status word has come back. The
  // first edge lets the checker's count catch up with the last accepted word.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // One burst: a quiet word that drops every bin, then a few words that
  // never exceed the threshold of the bin above a chosen bin and span no more
  // than that bin's tolerance. Tolerance shrinks as the threshold rises, so
  // no active bin can run over and the survived flag stays set; the sticky
  // flag would otherwise hide all later bin behavior. Some bursts hold the
  // chosen bin active for exactly its tolerance, the longest time that is
  // still allowed. Timestamps start anywhere, so bursts also wrap past 2^32.
  task automatic send_burst();
    int          bin;
    int          kind;
    int          n;
    int          cap;
    int          span;
    int          off;
    int          lvl;
    int          pick;
    int          top_cap;
    logic [31:0] t0;
    pick = $urandom_range(0, 3);
    lvl  = (pick == 0) ? 0 :
           (pick == 1) ? int'(i_check.thr_q8[0]) : $urandom_range(0, i_check.thr_q8[0]);
    push_word(16'(lvl), $urandom());

    // The ceiling on the top bin grows through the run so that the peak
    // keeps moving instead of sticking at full scale early on.
    top_cap = int'(i_check.thr_q8[NUM_BINS - 1]) + 1;
    top_cap = top_cap + ((65535 - top_cap) * sent) / TOTAL_WORDS;
    bin  = $urandom_range(0, NUM_BINS - 1);
    cap  = (bin == NUM_BINS - 1) ? top_cap : int'(i_check.thr_q8[bin + 1]);
    kind = $urandom_range(0, 9);
    n    = (kind == 3) ? 1 : $urandom_range(2, 10);
    span = (kind < 3) ? int'(i_check.tol_ms[bin]) : $urandom_range(0, i_check.tol_ms[bin]);
    t0   = $urandom();
    off  = 0;
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) begin
        off = span;
      end else if (k > 0) begin
        off = $urandom_range(off, span);
      end
      if (kind < 3) begin
        lvl = $urandom_range(i_check.thr_q8[bin] + 1, cap);
      end else begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: begin
            lvl = i_check.thr_q8[$urandom_range(0, (bin == NUM_BINS - 1) ? bin : bin + 1)];
          end
          1: begin
            lvl = i_check.thr_q8[$urandom_range(0, bin)] + 1;
          end
          default: begin
            lvl = $urandom_range(0, cap);
          end
        endcase
      end
      push_word(16'(lvl), t0 + 32'(off));
    end
  endtask

  initial begin
    int          bin;
    logic [31:0] t0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening words: zero sample at timestamp zero, a sample sitting exactly
    // on the lowest threshold, a staircase that raises every bin in turn,
    // a drop to exactly the top threshold and then to the lowest one.
    push_word(16'd0, 32'd0);
    push_word(i_check.thr_q8[0], 32'd1);
    for (int j = 0; j < NUM_BINS; j++) begin
      push_word(i_check.thr_q8[j] + 16'd1, 32'(2 + j));
    end
    push_word(i_check.thr_q8[NUM_BINS - 1], 32'd30);
    push_word(i_check.thr_q8[0], 32'd31);
    // The lowest bin held for exactly its tolerance across the timestamp
    // wrap: elapsed time equals the limit, which is still survivable.
    push_word(i_check.thr_q8[0] + 16'd1, 32'hFFFF_FFFA);
    push_word(i_check.thr_q8[0] + 16'd1, i_check.tol_ms[0] - 32'd6);
    push_word(16'd0, 32'hFFFF_FFFF);

    // Let the whole pipeline empty once before the random part.
    drain();

    while (sent < RANDOM_END) begin
      send_burst();
    end

    // Closing words. Exactly one event may clear the sticky flag, so the run
    // picks one: a bin started at timestamp zero and held one ms past its
    // tolerance, or a timestamp stepping back while a bin is active.
    bin = $urandom_range(0, NUM_BINS - 1);
    if ($urandom_range(0, 1) == 1) begin
      push_word(16'd0, 32'hFFFF_FFF0);
      push_word(i_check.thr_q8[bin] + 16'd1, 32'd0);
      push_word(i_check.thr_q8[bin] + 16'd1, i_check.tol_ms[bin] + 32'd1);
    end else begin
      t0 = $urandom();
      push_word(16'd0, t0);
      push_word(i_check.thr_q8[bin] + 16'd1, t0);
      push_word(i_check.thr_q8[bin] + 16'd1, t0 - 32'd1);
    end
    push_word(16'hFFFF, 32'hFFFF_FFFF);
    repeat (12) begin
      push_word(16'($urandom()), $urandom());
    end

    // Wait out every expected word, then a little longer than the pipeline
    // depth so a stray extra word would still be seen.
    drain();
    repeat (NUM_BINS + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/getm_pkg.sv
hw/rtl/getm_cell.sv
hw/rtl/getm_out.sv
hw/rtl/g_exposure_tolerance_monitor.sv
bench/exposure_checker.sv
bench/testbench.sv
